[sv/uzz_pkg.sv]
// Shared types and constants for the LEB128 / zigzag stream decoder.
package uzz_pkg;

  localparam int RAW_W      = 8;   // raw and logical byte width
  localparam int GROUP_W    = 7;   // payload bits per logical byte
  localparam int VAL_W      = 64;  // decoded value width
  localparam int CNT_W      = 4;   // group / byte count width
  localparam int SHAMT_W    = 7;   // group shift amount, up to 9 * 7
  localparam int OFFSET_W   = 3;   // bit offset register width
  localparam int CFG_IDX_W  = 1;   // configuration register index width
  localparam int CFG_DATA_W = 3;   // widest configuration register

  localparam logic [RAW_W-1:0] GROUP_MASK = 8'h7f;
  localparam logic [RAW_W-1:0] CONT_MASK  = 8'h80;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_OFFSET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZIGZAG_MODE = 1'b1;

  // Realigned logical byte handed from the aligner to the accumulator
  typedef struct packed {
    logic             valid;
    logic [RAW_W-1:0] data;
  } logical_t;

  // One decoded result
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] byte_count;
    logic             overflow;
  } result_t;

endpackage

[sv/uzz_align.sv]
// Realigns raw bytes into logical bytes at a configured bit offset.
module uzz_align (
  input  logic [2:0]         bit_offset,
  input  logic               have_previous,
  input  logic [7:0]         previous_raw,
  input  logic [7:0]         raw_byte,
  output uzz_pkg::logical_t  logical
);
  import uzz_pkg::*;

  logic [2*RAW_W-1:0] pair_shifted;

  // {current, previous} >> k gives (P >> k) | (C << (8 - k)) in the low byte
  assign pair_shifted = {raw_byte, previous_raw} >> bit_offset;

  always_comb begin
    if (bit_offset == '0) begin
      logical.valid = 1'b1;
      logical.data  = raw_byte;
    end else begin
      logical.valid = have_previous;
      logical.data  = pair_shifted[RAW_W-1:0];
    end
  end

endmodule

[sv/uzz_accum.sv]
// Gathers 7-bit groups into the varint accumulator and forms each result.
module uzz_accum #(
  parameter int MAX_GROUPS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  uzz_pkg::logical_t  logical,
  input  logic               zigzag_mode,
  output logic               res_valid,
  output uzz_pkg::result_t   res
);
  import uzz_pkg::*;

  logic [VAL_W-1:0]   accumulator;
  logic [VAL_W-1:0]   accumulator_next;
  logic [CNT_W-1:0]   group_count;
  logic [CNT_W-1:0]   group_count_next;
  logic [CNT_W-1:0]   groups_seen;
  logic [SHAMT_W-1:0] shamt;
  logic [VAL_W-1:0]   group_shifted;
  logic [VAL_W-1:0]   acc_merged;
  logic               last_byte;

  assign shamt         = SHAMT_W'({3'b000, group_count} * SHAMT_W'(GROUP_W));
  assign group_shifted = (shamt < SHAMT_W'(VAL_W))
                         ? (VAL_W'(logical.data & GROUP_MASK) << shamt[5:0])
                         : '0;
  assign acc_merged    = accumulator | group_shifted;
  assign groups_seen   = group_count + CNT_W'(1);
  assign last_byte     = (logical.data & CONT_MASK) == '0;

  always_comb begin
    res_valid        = 1'b0;
    res.value        = acc_merged;
    res.byte_count   = groups_seen;
    res.overflow     = 1'b0;
    accumulator_next = accumulator;
    group_count_next = group_count;
    if (en && logical.valid) begin
      priority if (last_byte) begin
        res_valid        = 1'b1;
        if (zigzag_mode) begin
          res.value = (acc_merged >> 1) ^ {VAL_W{acc_merged[0]}};
        end
        accumulator_next = '0;
        group_count_next = '0;
      end else if (groups_seen >= CNT_W'(MAX_GROUPS)) begin
        // too many groups: report overflow and restart
        res_valid        = 1'b1;
        res.value        = '0;
        res.byte_count   = CNT_W'(MAX_GROUPS);
        res.overflow     = 1'b1;
        accumulator_next = '0;
        group_count_next = '0;
      end else begin
        accumulator_next = acc_merged;
        group_count_next = groups_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      group_count <= '0;
    end else begin
      accumulator <= accumulator_next;
      group_count <= group_count_next;
    end
  end

endmodule

[sv/uleb128_zigzag_stream_decoder_unit.sv]
// Top level of the LEB128 varint stream decoder with optional zigzag decode.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    raw_byte[7:0]
//  out       source     out_valid / out_ready  value[63:0], byte_count[3:0], overflow
//  cfg       sink       cfg_wr_en (no wait)    cfg_index[0], cfg_data[2:0]
//
// One raw byte per cycle, sustained while the output is not stalled. A byte
// is held in the input register, then the realign / shift-or / continuation
// test lands its result in the output register.
// Synchronous active-high reset clears the control state, the accumulator and
// the registers (bit offset 0, unsigned mode).
// A stalled output register holds its transaction; the input register takes a
// byte only when it is empty or the byte in it can move on, i.e. the output
// register is empty or being drained in the same cycle.
module uleb128_zigzag_stream_decoder_unit #(
  parameter int MAX_GROUPS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  raw_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [3:0]  byte_count,
  output logic        overflow,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import uzz_pkg::*;

  // Configuration registers
  logic [OFFSET_W-1:0] bit_offset;
  logic                zigzag_mode;

  // Input register
  logic                s1_valid;
  logic [RAW_W-1:0]    s1_byte;

  // Realign history
  logic [RAW_W-1:0]    previous_raw;
  logic                have_previous;

  logic                step;
  logic                res_valid;
  logic                out_valid_next;

  logical_t            logical;
  result_t             res;
  result_t             out_res;

  // The byte in the input register moves on whenever the output slot is free
  assign step     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_offset  <= '0;
      zigzag_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BIT_OFFSET:  bit_offset  <= cfg_data[OFFSET_W-1:0];
        REG_ZIGZAG_MODE: zigzag_mode <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= raw_byte;
    end
  end

  // Every byte that leaves the input register becomes the new history byte
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
    end else if (step) begin
      have_previous <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      previous_raw <= s1_byte;
    end
  end

  uzz_align u_align (
    .bit_offset    (bit_offset),
    .have_previous (have_previous),
    .previous_raw  (previous_raw),
    .raw_byte      (s1_byte),
    .logical       (logical)
  );

  uzz_accum #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .en          (step),
    .logical     (logical),
    .zigzag_mode (zigzag_mode),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register: loads a fresh transaction, or drains when taken
  always_comb begin
    priority if (step && res_valid) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign value      = out_res.value;
  assign byte_count = out_res.byte_count;
  assign overflow   = out_res.overflow;

  // An overflow transaction carries a zero value and the full group count
  a_overflow_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> value == '0 && byte_count == CNT_W'(MAX_GROUPS))
    else $error("overflow transaction malformed");

  // Byte count stays within one to MAX_GROUPS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count != '0 && byte_count <= CNT_W'(MAX_GROUPS))
    else $error("byte count out of range");

  // Input stalls only behind a full input register and a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without cause");

  // No result can appear in the cycle right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

[verif/tb_uleb128_zigzag_stream_decoder_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the LEB128 / zigzag stream decoder top level.
module tb_uleb128_zigzag_stream_decoder_unit;
  import uzz_pkg::*;

  localparam int          MAX_GROUPS    = 10;
  localparam int          SETTLE_CYCLES = 4;       // input and output register plus margin
  localparam int          NUM_PHASES    = 12;
  localparam int          PHASE_ITEMS   = 100;
  localparam int unsigned CYCLE_LIMIT   = 200_000;

  // Directed stimulus rows: either one raw byte or one register write
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [RAW_W-1:0]        raw;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
    bit                      typed;   // expected result written in the row
    result_t                 want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [7:0]            raw_byte  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [63:0]           value;
  logic [3:0]            byte_count;
  logic                  overflow;
  logic                  cfg_wr_en = 1'b0;
  logic [0:0]            cfg_index = '0;
  logic [2:0]            cfg_data  = '0;

  // Decoder model state, mirrored from the block's behavior
  logic [RAW_W-1:0]      last_raw    = '0;
  logic                  have_last   = 1'b0;
  logic [VAL_W-1:0]      group_acc   = '0;
  logic [CNT_W-1:0]      groups_seen = '0;
  logic [OFFSET_W-1:0]   cur_offset  = '0;
  logic                  cur_zigzag  = 1'b0;

  result_t               expected_results[$];
  result_t               oldest_result;
  stim_row_t             directed_rows[$];
  int                    mismatch_count = 0;
  int unsigned           cycle_count    = 0;
  int                    src_idle_pct   = 35;
  int                    sink_idle_pct  = 35;

  uleb128_zigzag_stream_decoder_unit #(
    .MAX_GROUPS(MAX_GROUPS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_byte   (raw_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .byte_count (byte_count),
    .overflow   (overflow),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Appends one result to the scoreboard queue
  task automatic add_expected(input result_t r);
    expected_results = {expected_results, r};
  endtask

  // Appends one directed stimulus row
  task automatic append_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endtask

  // Feeds one raw byte through the varint model. Returns 1 when the byte
  // completes a varint (or trips the group limit) and fills in the result.
  function automatic bit decode_raw_byte(input logic [RAW_W-1:0] raw,
                                         output result_t res);
    logic [RAW_W-1:0]   logical;
    logic [2*RAW_W-1:0] pair;
    logic [CNT_W-1:0]   g;
    logic [VAL_W-1:0]   u;
    res = '0;
    if (cur_offset != 0 && !have_last) begin
      // nothing to pair with yet at a non-zero offset: just keep the byte
      last_raw  = raw;
      have_last = 1'b1;
      return 1'b0;
    end
    if (cur_offset == 0) begin
      logical = raw;
    end else begin
      // logical byte straddles previous and current raw byte
      pair    = {raw, last_raw};
      logical = pair[cur_offset +: RAW_W];
    end
    last_raw  = raw;
    have_last = 1'b1;

    // shifts past bit 63 drop the upper group bits
    if (groups_seen < 10)
      group_acc |= 64'(logical & GROUP_MASK) << (int'(groups_seen) * GROUP_W);
    g = groups_seen + 1'b1;

    if ((logical & CONT_MASK) == 0) begin
      u = group_acc;
      if (cur_zigzag)
        u = (u >> 1) ^ {VAL_W{u[0]}};
      res         = '{value: u, byte_count: g, overflow: 1'b0};
      group_acc   = '0;
      groups_seen = '0;
      return 1'b1;
    end
    if (g >= MAX_GROUPS) begin
      res         = '{value: '0, byte_count: CNT_W'(MAX_GROUPS), overflow: 1'b1};
      group_acc   = '0;
      groups_seen = '0;
      return 1'b1;
    end
    groups_seen = g;
    return 1'b0;
  endfunction

  // Sender pause: drop valid and wait until every result is back and the
  // pipe has had time to swallow bytes that produce nothing.
  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_decoder();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_BIT_OFFSET)
      cur_offset = data;
    else if (idx == REG_ZIGZAG_MODE)
      cur_zigzag = data[0];
  endtask

  // One input transaction. Called and returns on a falling edge; the model
  // runs on the accepting rising edge. A typed result overrides the model.
  task automatic send_byte(input logic [RAW_W-1:0] raw, input bit typed,
                           input result_t want);
    result_t predicted;
    bit      produced;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_byte <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = decode_raw_byte(raw, predicted);
    if (typed)
      add_expected(want);
    else if (produced)
      add_expected(predicted);
    @(negedge clk);
  endtask

  function automatic stim_row_t byte_row(input logic [RAW_W-1:0] raw);
    stim_row_t r;
    r       = '{kind: ROW_BYTE, raw: raw, reg_idx: '0, reg_data: '0,
                typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [RAW_W-1:0] raw,
                                            input logic [VAL_W-1:0] v,
                                            input logic [CNT_W-1:0] c,
                                            input logic o);
    stim_row_t r;
    r       = byte_row(raw);
    r.typed = 1'b1;
    r.want  = '{value: v, byte_count: c, overflow: o};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r          = byte_row('0);
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Result checker: every output transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("cycle %0d: unexpected result value %h count %0d ovf %0b",
                   cycle_count, value, byte_count, overflow);
      end else begin
        oldest_result = expected_results.pop_front();
        if (value !== oldest_result.value ||
            byte_count !== oldest_result.byte_count ||
            overflow !== oldest_result.overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("cycle %0d: exp %h/%0d/%0b got %h/%0d/%0b",
                     cycle_count, oldest_result.value, oldest_result.byte_count,
                     oldest_result.overflow, value, byte_count, overflow);
        end
      end
    end
  end

  initial begin
    stim_row_t        row;
    int               sent;
    int               len;
    int               fill;
    int               roll;
    int               cont_pos;
    logic [RAW_W-1:0] b;

    // --- directed rows ---
    // offset 7 straight after reset: first byte only gets stored
    append_row(cfg_row(REG_BIT_OFFSET, 3'd7));
    append_row(byte_row(8'haa));
    append_row(byte_row(8'h01));
    append_row(cfg_row(REG_BIT_OFFSET, 3'd0));
    append_row(checked_row(8'h00, 64'd0, 4'd1, 1'b0));
    // ten groups, tenth group only keeps bit 0 (here clear)
    repeat (9) append_row(byte_row(8'hff));
    append_row(checked_row(8'h7e, 64'h7fff_ffff_ffff_ffff, 4'd10, 1'b0));
    // ten continuation bytes in a row trip the group limit
    repeat (9) append_row(byte_row(8'h80));
    append_row(checked_row(8'h80, 64'd0, 4'(MAX_GROUPS), 1'b1));
    // mode switch in the middle of a varint: 128 zigzags to 64
    append_row(byte_row(8'h80));
    append_row(cfg_row(REG_ZIGZAG_MODE, 3'd1));
    append_row(checked_row(8'h01, 64'd64, 4'd2, 1'b0));
    append_row(checked_row(8'h01, '1, 4'd1, 1'b0));

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG)
        write_reg(row.reg_idx, row.reg_data);
      else
        send_byte(row.raw, row.typed, row.want);
    end

    // --- random phases ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      // both extremes of the offset first, then random settings
      write_reg(REG_BIT_OFFSET, (p == 0) ? 3'd0 : (p == 1) ? 3'd7 :
                CFG_DATA_W'($urandom_range(7)));
      write_reg(REG_ZIGZAG_MODE, (p < 4) ? CFG_DATA_W'(p[1]) :
                CFG_DATA_W'($urandom_range(1)));
      // one phase runs flat out on both sides
      src_idle_pct  = (p == 5) ? 0 : 35;
      sink_idle_pct = (p == 5) ? 0 : 35;
      cont_pos      = (cur_offset == 0) ? 7 : int'(cur_offset) - 1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          // noise byte
          send_byte(RAW_W'($urandom_range(255)), 1'b0, '0);
          sent++;
        end else begin
          // well-formed varint; the continuation bit of each logical byte
          // sits at a fixed raw bit for the current offset
          if (roll < 15)
            len = $urandom_range(15, 11);   // runs past the group limit
          else if (roll < 25)
            len = $urandom_range(10, 8);
          else
            len = $urandom_range(4, 1);
          fill = $urandom_range(3);
          for (int i = 0; i < len; i++) begin
            b = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 :
                RAW_W'($urandom_range(255));
            b[cont_pos] = (i != len - 1);
            send_byte(b, 1'b0, '0);
            sent++;
          end
        end
      end
      // the last varint of a phase may be cut short; the next phase's
      // register writes then land mid-stream
    end

    src_idle_pct  = 35;
    sink_idle_pct = 35;
    drain_decoder();
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[files.f]
sv/uzz_pkg.sv
sv/uzz_align.sv
sv/uzz_accum.sv
sv/uleb128_zigzag_stream_decoder_unit.sv
verif/tb_uleb128_zigzag_stream_decoder_unit.sv
